// ===== sv/fragment_reassembly_deframer_assert.svh =====
// Assertion macros shared by the deframer modules.
// Each macro takes a label, a clock, a reset and the property terms.
`ifndef FRAGMENT_REASSEMBLY_DEFRAMER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FRD_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("frd: assertion failed");
// Next-cycle implication.
`define FRD_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("frd: assertion failed");
`else
`define FRD_ASSERT_IMP(label, ck, rs, ante, cons)
`define FRD_ASSERT_NXT(label, ck, rs, ante, cons)
`endif
`endif

// ===== sv/frd_pkg.sv =====
package frd_pkg;

  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned HDR_IDX_W    = 5;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [HDR_IDX_W-1:0] HDR_START   = 5'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI  = 5'd4;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO  = 5'd5;
  localparam logic [HDR_IDX_W-1:0] HDR_CMD_HI  = 5'd6;
  localparam logic [HDR_IDX_W-1:0] HDR_CMD_LO  = 5'd7;
  localparam logic [HDR_IDX_W-1:0] HDR_TOT_HI  = 5'd16;
  localparam logic [HDR_IDX_W-1:0] HDR_TOT_LO  = 5'd17;
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_HI  = 5'd18;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST    = 5'(HEADER_BYTES - 1);

  // Configuration register indexes.
  localparam logic CFG_START_MARKER   = 1'b0;
  localparam logic CFG_MAX_PACKET_LEN = 1'b1;

  localparam logic [7:0]  START_MARKER_RST   = 8'hFF;
  localparam logic [15:0] MAX_PACKET_LEN_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_HDR_ERR   = 2'd1,
    KIND_EMPTY_END = 2'd2
  } kind_t;

  // One result item as it travels from the parser to the output stage.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        last_of_message;
    logic [15:0] command;
    logic [31:0] message_length;
  } res_t;

endpackage

// ===== sv/frd_front.sv =====
`include "fragment_reassembly_deframer_assert.svh"

module frd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_func,
  input  logic [7:0]     in_byte,
  input  logic           cfg_valid,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic           queue_ready,
  output logic           push,
  output frd_pkg::res_t  push_data
);

  logic [7:0]                     start_marker;
  logic [15:0]                    max_packet_len;
  logic                           in_body, in_body_next;
  logic [frd_pkg::HDR_IDX_W-1:0]  header_index, header_index_next;
  logic [15:0]                    frag_length, frag_length_next;
  logic [15:0]                    frag_command, frag_command_next;
  logic [15:0]                    frag_total, frag_total_next;
  logic [15:0]                    frag_index, frag_index_next;
  logic                           frag_final, frag_final_next;
  logic [15:0]                    body_remaining, body_remaining_next;
  logic [31:0]                    total_length, total_length_next;

  logic        accept;
  logic [15:0] rem_dec;
  logic [15:0] idx_full;
  logic        is_final;
  logic        len_bad;
  logic [15:0] body;
  logic [31:0] base_length;
  logic [32:0] sum_length;
  logic [31:0] new_length;

  assign accept   = in_valid && queue_ready;
  assign in_ready = queue_ready;

  // Header-end arithmetic; the index low byte arrives with the last header byte.
  assign rem_dec     = body_remaining - 16'd1;
  assign idx_full    = {frag_index[15:8], in_byte};
  assign is_final    = (frag_total == 16'd0) ||
                       ({1'b0, frag_total} == ({1'b0, idx_full} + 17'd1));
  assign len_bad     = (frag_length < 16'(frd_pkg::HEADER_BYTES)) ||
                       (frag_length > max_packet_len);
  assign body        = frag_length - 16'(frd_pkg::HEADER_BYTES);
  assign base_length = (idx_full == 16'd0) ? 32'd0 : total_length;
  assign sum_length  = {1'b0, base_length} + {17'd0, body};
  assign new_length  = sum_length[32] ? 32'hFFFF_FFFF : sum_length[31:0];

  always_comb begin
    in_body_next        = in_body;
    header_index_next   = header_index;
    frag_length_next    = frag_length;
    frag_command_next   = frag_command;
    frag_total_next     = frag_total;
    frag_index_next     = frag_index;
    frag_final_next     = frag_final;
    body_remaining_next = body_remaining;
    total_length_next   = total_length;
    push                = 1'b0;
    push_data           = '0;
    push_data.kind      = frd_pkg::KIND_PAYLOAD;

    if (accept) begin
      if (in_func) begin
        in_body_next        = 1'b0;
        header_index_next   = '0;
        frag_length_next    = '0;
        frag_command_next   = '0;
        frag_total_next     = '0;
        frag_index_next     = '0;
        frag_final_next     = 1'b0;
        body_remaining_next = '0;
        total_length_next   = '0;
      end else if (in_body) begin
        body_remaining_next    = rem_dec;
        push                   = 1'b1;
        push_data.kind         = frd_pkg::KIND_PAYLOAD;
        push_data.payload_byte = in_byte;
        if (rem_dec == 16'd0) begin
          in_body_next      = 1'b0;
          header_index_next = '0;
          if (frag_final) begin
            push_data.last_of_message = 1'b1;
            push_data.command         = frag_command;
            push_data.message_length  = total_length;
          end
        end
      end else if (header_index == frd_pkg::HDR_START && in_byte != start_marker) begin
        push           = 1'b1;
        push_data.kind = frd_pkg::KIND_HDR_ERR;
      end else begin
        unique case (header_index)
          frd_pkg::HDR_LEN_HI: frag_length_next  = {in_byte, 8'd0};
          frd_pkg::HDR_LEN_LO: frag_length_next  = {frag_length[15:8], in_byte};
          frd_pkg::HDR_CMD_HI: frag_command_next = {in_byte, 8'd0};
          frd_pkg::HDR_CMD_LO: frag_command_next = {frag_command[15:8], in_byte};
          frd_pkg::HDR_TOT_HI: frag_total_next   = {in_byte, 8'd0};
          frd_pkg::HDR_TOT_LO: frag_total_next   = {frag_total[15:8], in_byte};
          frd_pkg::HDR_IDX_HI: frag_index_next   = {in_byte, 8'd0};
          frd_pkg::HDR_LAST:   frag_index_next   = idx_full;
          default: ;
        endcase

        if (header_index != frd_pkg::HDR_LAST) begin
          header_index_next = header_index + 5'd1;
        end else begin
          header_index_next = '0;
          if (len_bad) begin
            push           = 1'b1;
            push_data.kind = frd_pkg::KIND_HDR_ERR;
          end else begin
            total_length_next = new_length;
            frag_final_next   = is_final;
            if (body == 16'd0) begin
              if (is_final) begin
                push                      = 1'b1;
                push_data.kind            = frd_pkg::KIND_EMPTY_END;
                push_data.last_of_message = 1'b1;
                push_data.command         = frag_command;
                push_data.message_length  = new_length;
              end
            end else begin
              in_body_next        = 1'b1;
              body_remaining_next = body;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker   <= frd_pkg::START_MARKER_RST;
      max_packet_len <= frd_pkg::MAX_PACKET_LEN_RST;
      in_body        <= 1'b0;
      header_index   <= '0;
      frag_length    <= '0;
      frag_command   <= '0;
      frag_total     <= '0;
      frag_index     <= '0;
      frag_final     <= 1'b0;
      body_remaining <= '0;
      total_length   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          frd_pkg::CFG_START_MARKER:   start_marker   <= cfg_data[7:0];
          frd_pkg::CFG_MAX_PACKET_LEN: max_packet_len <= cfg_data;
          default: ;
        endcase
      end
      in_body        <= in_body_next;
      header_index   <= header_index_next;
      frag_length    <= frag_length_next;
      frag_command   <= frag_command_next;
      frag_total     <= frag_total_next;
      frag_index     <= frag_index_next;
      frag_final     <= frag_final_next;
      body_remaining <= body_remaining_next;
      total_length   <= total_length_next;
    end
  end

  `FRD_ASSERT_IMP(a_body_at_hdr_start, clk, rst, in_body, header_index == '0)
  `FRD_ASSERT_IMP(a_discard_silent, clk, rst, accept && in_func, !push)
  `FRD_ASSERT_NXT(a_body_ends, clk, rst,
                  accept && !in_func && in_body && body_remaining == 16'd1, !in_body)

endmodule

// ===== sv/frd_queue.sv =====
`include "fragment_reassembly_deframer_assert.svh"

module frd_queue #(
  parameter int unsigned DEPTH = frd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  frd_pkg::res_t  push_data,
  output logic           push_ready,
  output logic           pop_valid,
  input  logic           pop,
  output frd_pkg::res_t  pop_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frd_pkg::res_t      entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count < CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `FRD_ASSERT_IMP(a_no_overflow, clk, rst, push, count < CNT_W'(DEPTH))

endmodule

// ===== sv/frd_back.sv =====
module frd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  frd_pkg::res_t  q_data,
  output logic           q_pop,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [55:0]    m_axis_tdata,
  output logic [1:0]     m_axis_tuser,
  output logic           m_axis_tlast
);

  frd_pkg::res_t out_reg;
  logic          out_valid;

  // Load a new item whenever the output register is empty or being drained.
  assign q_pop = q_valid && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_reg <= q_data;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_reg.message_length, out_reg.command, out_reg.payload_byte};
  assign m_axis_tuser  = out_reg.kind;
  assign m_axis_tlast  = out_reg.last_of_message;

endmodule

// ===== sv/fragment_reassembly_deframer.sv =====
// Fragment reassembly deframer. Bytes of a received stream enter one per
// transfer on the slave side; each fragment opens with a 20-byte big-endian
// header whose start byte must equal the start_marker register and whose
// length field (header included) must lie between 20 and max_packet_len.
// Body bytes leave one per transfer on the master side; the last body byte
// of a final fragment (fragment total 0, or index + 1 equal to the total)
// carries tlast together with the command word and the message length
// summed over all fragments since the last fragment index of 0, saturating
// at all ones. A final fragment without body gives an empty end marker, and
// a header that fails its check gives a header error item, after which the
// header search starts over. A transfer with tuser set discards all parse
// state but leaves the registers and results already produced untouched.
// The block takes one byte every cycle: the parser finishes each byte in
// the cycle it is accepted, so the only limit is a free slot in the result
// queue, which stays free while the master side takes a result per cycle.
// A result passes through the queue and then the output register on its
// way to the master side. Configuration writes are always ready and should
// be issued only while no bytes are in flight.
module fragment_reassembly_deframer #(
  parameter int unsigned QUEUE_DEPTH = frd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] func: discard and restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] command,
                                      // [55:24] message_length
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,   // last_of_message
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic          queue_ready;
  logic          push;
  frd_pkg::res_t push_data;
  logic          q_valid;
  logic          q_pop;
  frd_pkg::res_t q_data;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;

  // Front: header parsing, fragment bookkeeping and result classification.
  frd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_func     (s_axis_tuser),
    .in_byte     (s_axis_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .queue_ready (queue_ready),
    .push        (push),
    .push_data   (push_data)
  );

  // Short result queue so that the parser and the output can stall apart.
  frd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (queue_ready),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // Back: output register and packing onto the master side.
  frd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Scoreboard for the deframer. It keeps its own copy of the parse state and
// of both registers, turns every accepted byte into the results that byte
// must cause, and compares each result that leaves the block with the oldest
// one still waiting.
class deframer_scoreboard;
  localparam int unsigned PRINT_CAP = 40;

  logic [7:0]  marker;
  logic [15:0] max_len;

  bit          in_body;
  logic [4:0]  hdr_pos;
  logic [15:0] frag_len;
  logic [15:0] frag_cmd;
  logic [15:0] frag_total;
  logic [15:0] frag_idx;
  logic [15:0] body_left;
  logic [31:0] msg_len;

  frd_pkg::res_t pending[$];
  int unsigned   errors;

  function new();
    marker  = frd_pkg::START_MARKER_RST;
    max_len = frd_pkg::MAX_PACKET_LEN_RST;
    errors  = 0;
    clear();
  endfunction

  function void clear();
    in_body    = 1'b0;
    hdr_pos    = '0;
    frag_len   = '0;
    frag_cmd   = '0;
    frag_total = '0;
    frag_idx   = '0;
    body_left  = '0;
    msg_len    = '0;
  endfunction

  function void set_register(logic idx, logic [15:0] value);
    if (idx == frd_pkg::CFG_START_MARKER) marker = value[7:0];
    else max_len = value;
  endfunction

  // The index test is done one bit wider, so index 65535 never wraps to 0.
  function bit final_fragment();
    return frag_total == 16'd0 || {1'b0, frag_total} == {1'b0, frag_idx} + 17'd1;
  endfunction

  function void expect_result(frd_pkg::kind_t kind, logic [7:0] b, bit last);
    frd_pkg::res_t r;
    r.kind            = kind;
    r.payload_byte    = b;
    r.last_of_message = last;
    r.command         = last ? frag_cmd : 16'd0;
    r.message_length  = last ? msg_len : 32'd0;
    pending.push_back(r);
  endfunction

  function void note_byte(logic discard, logic [7:0] b);
    logic [31:0] body;
    if (discard) begin
      clear();
      return;
    end
    if (in_body) begin
      body_left = body_left - 16'd1;
      if (body_left == 16'd0) begin
        in_body = 1'b0;
        hdr_pos = '0;
        expect_result(frd_pkg::KIND_PAYLOAD, b, final_fragment());
      end else begin
        expect_result(frd_pkg::KIND_PAYLOAD, b, 1'b0);
      end
      return;
    end
    case (hdr_pos)
      frd_pkg::HDR_START: begin
        if (b != marker) begin
          hdr_pos = '0;
          expect_result(frd_pkg::KIND_HDR_ERR, 8'd0, 1'b0);
          return;
        end
      end
      frd_pkg::HDR_LEN_HI: frag_len = {b, 8'h00};
      frd_pkg::HDR_LEN_LO: frag_len[7:0] = b;
      frd_pkg::HDR_CMD_HI: frag_cmd = {b, 8'h00};
      frd_pkg::HDR_CMD_LO: frag_cmd[7:0] = b;
      frd_pkg::HDR_TOT_HI: frag_total = {b, 8'h00};
      frd_pkg::HDR_TOT_LO: frag_total[7:0] = b;
      frd_pkg::HDR_IDX_HI: frag_idx = {b, 8'h00};
      frd_pkg::HDR_LAST:   frag_idx[7:0] = b;
      default: ;
    endcase
    if (hdr_pos != frd_pkg::HDR_LAST) begin
      hdr_pos = hdr_pos + 5'd1;
      return;
    end
    hdr_pos = '0;
    if (frag_len < frd_pkg::HEADER_BYTES || frag_len > max_len) begin
      expect_result(frd_pkg::KIND_HDR_ERR, 8'd0, 1'b0);
      return;
    end
    if (frag_idx == 16'd0) msg_len = '0;
    body = 32'(frag_len) - frd_pkg::HEADER_BYTES;
    if (msg_len > 32'hFFFF_FFFF - body) msg_len = 32'hFFFF_FFFF;
    else msg_len = msg_len + body;
    if (body == 0) begin
      if (final_fragment()) expect_result(frd_pkg::KIND_EMPTY_END, 8'd0, 1'b1);
      return;
    end
    in_body   = 1'b1;
    body_left = body[15:0];
  endfunction

  task report(string what);
    errors++;
    if (errors <= PRINT_CAP) $display("deframer check: %s", what);
  endtask

  task check_result(frd_pkg::res_t got);
    frd_pkg::res_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result, kind %0d byte %02h", got.kind, got.payload_byte));
      return;
    end
    want = pending.pop_front();
    if (got.kind != want.kind)
      report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
    if (got.payload_byte != want.payload_byte)
      report($sformatf("payload byte %02h, expected %02h", got.payload_byte,
                       want.payload_byte));
    if (got.last_of_message != want.last_of_message)
      report($sformatf("last %0b, expected %0b", got.last_of_message,
                       want.last_of_message));
    if (got.command != want.command)
      report($sformatf("command %04h, expected %04h", got.command, want.command));
    if (got.message_length != want.message_length)
      report($sformatf("message length %0d, expected %0d", got.message_length,
                       want.message_length));
  endtask
endclass

module testbench;
  // Results pass through the result queue and the output register on their
  // way out, so SETTLE_CYCLES quiet cycles are enough to be sure nothing is still in flight.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_BYTES   = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'd0;

  deframer_scoreboard board = new();

  // Idle and stall rates, in percent, changed from phase to phase.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;

  fragment_reassembly_deframer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // The receiver stalls at random; the rate follows the current phase.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Every master-side transfer is unpacked and checked against the oldest
  // expected result. Values are read at the edge, before the block's own
  // registers move, so the order of processes within the step is irrelevant.
  always @(posedge clk) begin
    frd_pkg::res_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind            = frd_pkg::kind_t'(m_axis_tuser);
      got.payload_byte    = m_axis_tdata[7:0];
      got.command         = m_axis_tdata[23:8];
      got.message_length  = m_axis_tdata[55:24];
      got.last_of_message = m_axis_tlast;
      board.check_result(got);
    end
  end

  // One slave-side transfer, preceded by a random number of idle cycles.
  // The expectation is noted only once the transfer has really happened.
  task automatic push_byte(logic discard, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= discard;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    board.note_byte(discard, b);
    bytes_sent++;
  endtask

  // A full header with random filler in the fields the block ignores, then
  // as many body bytes as asked; fewer than the length field implies leaves
  // the fragment open, which the caller closes with a discard.
  task automatic send_fragment(logic [7:0] mark, logic [15:0] len, logic [15:0] cmd,
                               logic [15:0] total, logic [15:0] idx,
                               int unsigned body_bytes);
    logic [7:0] hdr [frd_pkg::HEADER_BYTES];
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[frd_pkg::HDR_START]  = mark;
    hdr[frd_pkg::HDR_LEN_HI] = len[15:8];
    hdr[frd_pkg::HDR_LEN_LO] = len[7:0];
    hdr[frd_pkg::HDR_CMD_HI] = cmd[15:8];
    hdr[frd_pkg::HDR_CMD_LO] = cmd[7:0];
    hdr[frd_pkg::HDR_TOT_HI] = total[15:8];
    hdr[frd_pkg::HDR_TOT_LO] = total[7:0];
    hdr[frd_pkg::HDR_IDX_HI] = idx[15:8];
    hdr[frd_pkg::HDR_LAST]   = idx[7:0];
    foreach (hdr[i]) push_byte(1'b0, hdr[i]);
    repeat (body_bytes) push_byte(1'b0, 8'($urandom));
  endtask

  // Waits until every expected result has come out, then lets the block settle
  // so that bytes without a result have surely cleared the parser. Anything
  // still missing after the limit is reported once and dropped.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending.size() != 0) begin
      board.report($sformatf("%0d expected results never arrived", board.pending.size()));
      board.pending.delete();
    end
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, value);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic apply_settings(logic [7:0] marker, logic [15:0] max_len);
    drain();
    write_reg(frd_pkg::CFG_START_MARKER, {8'd0, marker});
    write_reg(frd_pkg::CFG_MAX_PACKET_LEN, max_len);
    cfg_valid <= 1'b0;
  endtask

  // Body size for a well-formed fragment: mostly a few bytes, now and then
  // a longer one, never beyond what the length limit allows.
  function automatic int unsigned pick_body();
    int unsigned room;
    room = int'(board.max_len) - frd_pkg::HEADER_BYTES;
    if ($urandom_range(9) == 0) return $urandom_range(0, (room < 48) ? room : 48);
    return $urandom_range(0, (room < 6) ? room : 6);
  endfunction

  // One random chunk of traffic. Most of it is well-formed messages of one
  // to four fragments, so the body path and the length summing get real
  // exercise; the rest is single fragments with arbitrary total and index, bad
  // lengths, wrong start bytes, noise and fragments cut short by a discard.
  task automatic random_traffic();
    int unsigned mode;
    int unsigned nfrag;
    int unsigned body;
    logic [15:0] total;
    logic [15:0] len;
    logic [15:0] idx;
    logic [7:0]  b;
    mode = $urandom_range(99);
    if (mode < 62) begin
      nfrag = $urandom_range(1, 4);
      total = ($urandom_range(6) == 0) ? 16'd0 : 16'(nfrag);
      for (int unsigned f = 0; f < nfrag; f++) begin
        body = pick_body();
        send_fragment(board.marker, 16'(frd_pkg::HEADER_BYTES + body), 16'($urandom),
                      total, 16'(f), body);
      end
    end else if (mode < 70) begin
      // Arbitrary total and index, sometimes placed right on the final test
      // or on the index that would wrap.
      total = 16'($urandom);
      case ($urandom_range(2))
        0: idx = total - 16'd1;
        1: idx = 16'hFFFF;
        default: idx = 16'($urandom);
      endcase
      body = pick_body();
      send_fragment(board.marker, 16'(frd_pkg::HEADER_BYTES + body), 16'($urandom),
                    total, idx, body);
    end else if (mode < 80) begin
      if (board.max_len != 16'hFFFF && $urandom_range(1) == 1)
        len = 16'($urandom_range(int'(board.max_len) + 1, 65535));
      else
        len = 16'($urandom_range(0, frd_pkg::HEADER_BYTES - 1));
      send_fragment(board.marker, len, 16'($urandom), 16'($urandom), 16'($urandom), 0);
    end else if (mode < 88) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        if (b == board.marker) b = ~b;
        push_byte(1'b0, b);
      end
    end else if (mode < 94) begin
      // A header with any length at all, a short piece of body, then a
      // discard; this is how the upper length bits get covered cheaply.
      send_fragment(board.marker, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), $urandom_range(0, 4));
      push_byte(1'b1, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) push_byte(1'b0, 8'($urandom));
      push_byte(1'b1, 8'($urandom));
    end
  endtask

  task automatic random_phase(int unsigned idle, int unsigned stall,
                              logic [7:0] marker, logic [15:0] max_len);
    int unsigned first;
    apply_settings(marker, max_len);
    idle_pct  = idle;
    stall_pct = stall;
    first = bytes_sent;
    while (bytes_sent - first < PHASE_BYTES) random_traffic();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset register values (start byte FF, no real
    // length limit).
    // A wrong start byte gives a header error straight away.
    push_byte(1'b0, 8'h00);
    // A single final fragment with total 0 and the extreme command word.
    send_fragment(8'hFF, 16'd23, 16'hFFFF, 16'd0, 16'd0, 3);
    // A final fragment without body is an empty end marker.
    send_fragment(8'hFF, 16'd20, 16'h0000, 16'd1, 16'd0, 0);
    // Three fragments: an empty opener gives nothing, the sum is carried on.
    send_fragment(8'hFF, 16'd20, 16'h1234, 16'd3, 16'd0, 0);
    send_fragment(8'hFF, 16'd22, 16'h5678, 16'd3, 16'd1, 2);
    send_fragment(8'hFF, 16'd21, 16'h9ABC, 16'd3, 16'd2, 1);
    // Lengths below the header size are header errors.
    send_fragment(8'hFF, 16'd19, 16'h0001, 16'd0, 16'd0, 0);
    send_fragment(8'hFF, 16'd0, 16'h0002, 16'd0, 16'd0, 0);
    // Index 65535 is not final against a nonzero total, but is with total 0.
    send_fragment(8'hFF, 16'd21, 16'h00FF, 16'd5, 16'hFFFF, 1);
    send_fragment(8'hFF, 16'd21, 16'hFF00, 16'd0, 16'hFFFF, 1);
    // A discard in the middle of a header, then in the middle of a body of
    // the largest length.
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, 8'h12);
    push_byte(1'b1, 8'h5A);
    send_fragment(8'hFF, 16'hFFFF, 16'hA5A5, 16'd0, 16'd0, 2);
    push_byte(1'b1, 8'hFF);

    // With a tight limit, one byte too long is rejected and the limit holds.
    apply_settings(8'hFF, 16'd30);
    send_fragment(8'hFF, 16'd31, 16'h0F0F, 16'd0, 16'd0, 0);
    send_fragment(8'hFF, 16'd30, 16'hF0F0, 16'd0, 16'd0, 10);

    // Random phases, each with its own register setting and idle pattern.
    random_phase(0, 0, 8'h00, 16'd20);
    random_phase(87, 0, 8'hFF, 16'hFFFF);
    random_phase(0, 87, 8'($urandom), 16'($urandom_range(20, 80)));
    random_phase(20, 20, 8'($urandom), 16'($urandom_range(20, 65535)));

    drain();
    if (board.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
